>>> rtl/msbd_pkg.sv
// Shared types and constants for the multi-sender bit deserializer.
package msbd_pkg;

    localparam int DEF_SLOT_COUNT     = 16;
    localparam int DEF_MESSAGE_LENGTH = 256;

    localparam int ID_W     = 22;
    localparam int CHAR_W   = 8;
    localparam int BITCNT_W = 3;
    localparam int POS_W    = 8;
    localparam int SLOT_W   = 4;

    localparam logic [CHAR_W-1:0]   NUL_CHAR = 8'h00;
    localparam logic [BITCNT_W-1:0] LAST_BIT = 3'd7;

    // Control flow of one transaction
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RMW
    } state_t;

    // Per-slot reception state kept in the slot memory
    typedef struct packed {
        logic [CHAR_W-1:0]   partial;
        logic [BITCNT_W-1:0] bit_count;
        logic [POS_W-1:0]    position;
    } slot_entry_t;

    // Outcome of the owner lookup
    typedef struct packed {
        logic found;
        logic claim;
    } lookup_t;

endpackage

>>> rtl/msbd_slot_ram.sv
// Synchronous slot memory with one write port and one registered read port.
module msbd_slot_ram #(
    parameter int DEPTH = msbd_pkg::DEF_SLOT_COUNT,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  msbd_pkg::slot_entry_t wdata,
    input  logic [AW-1:0]         raddr,
    output msbd_pkg::slot_entry_t rdata
);

    msbd_pkg::slot_entry_t mem [DEPTH];
    msbd_pkg::slot_entry_t rdata_reg;

    // Write the entry back
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read through a registered output
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/msbd_owner_cam.sv
// Owner table: matches a sender against all slots and claims or frees slots.
module msbd_owner_cam #(
    parameter int SLOT_COUNT = msbd_pkg::DEF_SLOT_COUNT,
    parameter int AW         = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [msbd_pkg::ID_W-1:0] id,
    input  logic                      look_en,
    input  logic                      free_en,
    input  logic [AW-1:0]             free_idx,
    output msbd_pkg::lookup_t         lk,
    output logic [AW-1:0]             idx
);

    logic [msbd_pkg::ID_W-1:0] owner_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]     hit_vec;
    logic [SLOT_COUNT-1:0]     free_vec;
    logic [AW-1:0]             hit_idx;
    logic [AW-1:0]             free_first;
    logic                      any_hit;
    logic                      any_free;
    logic                      id_ok;

    assign id_ok = (id != '0);

    // Compare every slot in parallel
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit_vec[i]  = id_ok && (owner_reg[i] == id);
            free_vec[i] = (owner_reg[i] == '0);
        end
    end

    // Encode the lowest matching and lowest free slot
    always_comb
    begin
        hit_idx    = '0;
        free_first = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = AW'(i);
            end
            if (free_vec[i])
            begin
                free_first = AW'(i);
            end
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;

    assign lk.found = any_hit;
    assign lk.claim = !any_hit && any_free && id_ok;
    assign idx      = any_hit ? hit_idx : free_first;

    // Claim a slot on lookup, drop ownership at end of message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owner_reg[i] <= '0;
            end
        end
        else
        begin
            if (look_en && lk.claim)
            begin
                owner_reg[idx] <= id;
            end
            if (free_en)
            begin
                owner_reg[free_idx] <= '0;
            end
        end
    end

endmodule

>>> rtl/multi_sender_bit_deserializer.sv
// Top level: sequencer and read-modify-write datapath of the bit deserializer.
// Flow: an accepted bit passes the owner lookup and read-modify-write states,
// and the result strobe is registered from the read-modify-write state.
// Sequence: idle, owner lookup, slot memory read-modify-write behind its
// registered read; a new bit is taken only in idle, and an ignored or dropped
// bit skips the read-modify-write and returns to idle.
// Reset: rst_n clears all slot owners and the sequencer at once; slot memory
// contents are cleared when a slot is claimed. The receiver cannot stall results.
module multi_sender_bit_deserializer #(
    parameter int SLOT_COUNT     = msbd_pkg::DEF_SLOT_COUNT,
    parameter int MESSAGE_LENGTH = msbd_pkg::DEF_MESSAGE_LENGTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [msbd_pkg::ID_W-1:0]   sender_id,
    input  logic                        rx_bit,
    output logic                        done,
    output logic [msbd_pkg::SLOT_W-1:0] slot,
    output logic [msbd_pkg::ID_W-1:0]   source_id,
    output logic [msbd_pkg::CHAR_W-1:0] character,
    output logic [msbd_pkg::POS_W-1:0]  position,
    output logic                        end_of_message,
    output logic                        overflow
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [msbd_pkg::POS_W-1:0] LAST_POS =
        (MESSAGE_LENGTH >= 256) ? 8'd255 : msbd_pkg::POS_W'(MESSAGE_LENGTH - 1);

    msbd_pkg::state_t      state_reg, state_next;
    logic [msbd_pkg::ID_W-1:0] id_reg;
    logic                  bit_reg;
    logic [AW-1:0]         idx_reg;
    logic                  claim_reg;

    msbd_pkg::lookup_t     lk;
    logic [AW-1:0]         lk_idx;
    msbd_pkg::slot_entry_t rd_data;
    msbd_pkg::slot_entry_t cur;
    msbd_pkg::slot_entry_t wr_data;
    logic                  look_en;
    logic                  rmw_en;
    logic                  accept;

    logic [msbd_pkg::CHAR_W-1:0] new_byte;
    logic [msbd_pkg::POS_W-1:0]  pos_sat;
    logic                        char_done;
    logic                        is_nul;
    logic                        free_en;

    logic                        done_reg;
    logic [msbd_pkg::SLOT_W-1:0] slot_reg;
    logic [msbd_pkg::ID_W-1:0]   source_reg;
    logic [msbd_pkg::CHAR_W-1:0] char_reg;
    logic [msbd_pkg::POS_W-1:0]  pos_reg;
    logic                        eom_reg;
    logic                        ovf_reg;

    assign busy    = (state_reg != msbd_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign look_en = (state_reg == msbd_pkg::ST_LOOK);
    assign rmw_en  = (state_reg == msbd_pkg::ST_RMW);

    msbd_owner_cam #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_cam (
        .clk      (clk),
        .rst_n    (rst_n),
        .id       (id_reg),
        .look_en  (look_en),
        .free_en  (free_en),
        .free_idx (idx_reg),
        .lk       (lk),
        .idx      (lk_idx)
    );

    msbd_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (rmw_en),
        .waddr (idx_reg),
        .wdata (wr_data),
        .raddr (lk_idx),
        .rdata (rd_data)
    );

    // Hold state and sequence the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msbd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msbd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = msbd_pkg::ST_LOOK;
                end
            end
            msbd_pkg::ST_LOOK:
            begin
                if (lk.found || lk.claim)
                begin
                    state_next = msbd_pkg::ST_RMW;
                end
                else
                begin
                    state_next = msbd_pkg::ST_IDLE;
                end
            end
            msbd_pkg::ST_RMW:
            begin
                state_next = msbd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = msbd_pkg::ST_IDLE;
            end
        endcase
    end

    // Capture the incoming transaction and the lookup outcome
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg  <= sender_id;
            bit_reg <= rx_bit;
        end
        if (look_en)
        begin
            idx_reg   <= lk_idx;
            claim_reg <= lk.claim;
        end
    end

    // Modify the slot entry: a fresh claim starts from zero
    always_comb
    begin
        cur       = claim_reg ? '0 : rd_data;
        new_byte  = cur.partial |
                    (msbd_pkg::CHAR_W'(bit_reg) << cur.bit_count);
        char_done = (cur.bit_count == msbd_pkg::LAST_BIT);
        pos_sat   = (cur.position > LAST_POS) ? LAST_POS : cur.position;
        is_nul    = (new_byte == msbd_pkg::NUL_CHAR);
        free_en   = rmw_en && char_done && is_nul;

        wr_data = cur;
        if (!char_done)
        begin
            wr_data.partial   = new_byte;
            wr_data.bit_count = cur.bit_count + msbd_pkg::BITCNT_W'(1);
        end
        else
        begin
            wr_data.partial   = '0;
            wr_data.bit_count = '0;
            if (is_nul)
            begin
                wr_data.position = '0;
            end
            else if (pos_sat < LAST_POS)
            begin
                wr_data.position = pos_sat + msbd_pkg::POS_W'(1);
            end
            else
            begin
                wr_data.position = LAST_POS;
            end
        end
    end

    // Strobe a finished character for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rmw_en && char_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rmw_en && char_done)
        begin
            slot_reg   <= msbd_pkg::SLOT_W'(idx_reg);
            source_reg <= id_reg;
            char_reg   <= new_byte;
            pos_reg    <= pos_sat;
            eom_reg    <= is_nul;
            ovf_reg    <= !is_nul && (pos_sat == LAST_POS);
        end
    end

    assign done           = done_reg;
    assign slot           = slot_reg;
    assign source_id      = source_reg;
    assign character      = char_reg;
    assign position       = pos_reg;
    assign end_of_message = eom_reg;
    assign overflow       = ovf_reg;

    // A result only follows a read-modify-write cycle
    a_done_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == msbd_pkg::ST_RMW))
        else $error("result strobe without a read-modify-write cycle");

    // End of message carries the NUL character and never overflows
    a_eom_nul: assert property (@(posedge clk) disable iff (!rst_n)
        done && end_of_message |-> (character == msbd_pkg::NUL_CHAR) && !overflow)
        else $error("end of message with a non-NUL character or overflow");

    // An accepted transaction always goes to lookup
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == msbd_pkg::ST_LOOK))
        else $error("accepted transaction did not enter lookup");

    // Position never passes the last buffer position
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (position <= LAST_POS))
        else $error("position beyond last buffer position");

endmodule
